FILE: rtl/core/nnaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnaf_pkg - shared types and constants for the neighbor average filter
// Pixel formats, register map, queue word layout and channel field tables.
// ----------------------------------------------------------------------------
package nnaf_pkg;

    // Stored pixel bits: every channel field of every format lies below bit 24
    localparam int unsigned PIX_W   = 24;
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Configuration register map (word index)
    localparam int unsigned APB_AW = 4;
    typedef enum logic [1:0] {
        REG_PIXEL_FORMAT    = 2'd0,
        REG_CHANNEL_ENABLES = 2'd1,
        REG_CLEAR_TO_BLACK  = 2'd2
    } t_reg_idx;

    // Pixel format codes; the unused code decodes as 888
    typedef enum logic [1:0] {
        FMT_555 = 2'd0,
        FMT_565 = 2'd1,
        FMT_888 = 2'd2
    } t_fmt;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // Word handed from front to back through the queue
    typedef struct packed {
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] left;
        logic [2:0]       raise;  // bit0 red, bit1 green, bit2 blue
    } t_fe_word;

    // Channel field mask for a format code and channel
    function automatic logic [PIX_W-1:0] ch_mask(input logic [1:0] fmt, input logic [1:0] ch);
        logic [PIX_W-1:0] m;
        m = '0;
        case (fmt)
            FMT_555: begin
                case (ch)
                    CH_RED:   m = 24'h007C00;
                    CH_GREEN: m = 24'h0003E0;
                    default:  m = 24'h00001F;
                endcase
            end
            FMT_565: begin
                case (ch)
                    CH_RED:   m = 24'h00F800;
                    CH_GREEN: m = 24'h0007C0;
                    default:  m = 24'h00001F;
                endcase
            end
            default: begin
                case (ch)
                    CH_RED:   m = 24'hF80000;
                    CH_GREEN: m = 24'h00F800;
                    default:  m = 24'h0000F8;
                endcase
            end
        endcase
        return m;
    endfunction

    // One 5-bit step: the lowest bit of the channel field
    function automatic logic [PIX_W-1:0] ch_step(input logic [1:0] fmt, input logic [1:0] ch);
        logic [PIX_W-1:0] m;
        m = ch_mask(fmt, ch);
        return m & (~m + 24'd1);
    endfunction

    // Stored form of an incoming pixel: 16-bit formats drop the upper half
    function automatic logic [PIX_W-1:0] pix_trim(input logic [1:0] fmt, input logic [31:0] pix);
        logic [PIX_W-1:0] p;
        p = pix[PIX_W-1:0];
        if (fmt == FMT_555 || fmt == FMT_565) begin
            p = {8'd0, pix[15:0]};
        end
        return p;
    endfunction

endpackage

FILE: rtl/core/nnaf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnaf_if - stream channels of the neighbor average filter
// Input pixel channel and filtered pixel channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface nnaf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_in;
    logic        frame_start;
    logic        raise_red;
    logic        raise_green;
    logic        raise_blue;

    modport source (
        output valid, pixel_in, frame_start, raise_red, raise_green, raise_blue,
        input  ready
    );
    modport sink (
        input  valid, pixel_in, frame_start, raise_red, raise_green, raise_blue,
        output ready
    );
endinterface

interface nnaf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;

    modport source (
        output valid, pixel_out,
        input  ready
    );
    modport sink (
        input  valid, pixel_out,
        output ready
    );
endinterface

FILE: rtl/core/noisy_neighbor_average_filter_unit.sv
`timescale 1ns / 1ps
// Path: each pixel passes the neighbor register, the queue and the output register.
// Throughput: one pixel per clock while the queue has room; one line memory read
//   and write per pixel at one address; the four-word queue absorbs output stalls.
// Reset: column, first-line count, previous pixel, queue and handshakes clear;
//   registers return to format 888, all channels on, black mode off. The line memory
//   is not cleared: upper neighbors read as zero until a full line is written.
// ----------------------------------------------------------------------------
// noisy_neighbor_average_filter_unit - neighbor average filter top level
// APB register block, pixel intake, word queue and channel filter.
// ----------------------------------------------------------------------------
module noisy_neighbor_average_filter_unit #(
    parameter int unsigned LINE_WIDTH = 336
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nnaf_in_if.sink                       i_in,
    nnaf_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nnaf_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import nnaf_pkg::*;

    logic [1:0] r_fmt;
    logic [2:0] r_enables;
    logic       r_black;
    logic       wr_en;
    logic [1:0] reg_idx;

    t_fe_word             fe_word;
    t_fe_word             q_word;
    logic                 fe_push;
    logic                 q_valid;
    logic                 q_pop;
    logic [Q_CNT_W-1:0]   q_level;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= FMT_888;
            r_enables <= 3'b111;
            r_black   <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_PIXEL_FORMAT:    r_fmt     <= pwdata[1:0];
                REG_CHANNEL_ENABLES: r_enables <= pwdata[2:0];
                REG_CLEAR_TO_BLACK:  r_black   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (reg_idx)
            REG_PIXEL_FORMAT:    prdata = {30'd0, r_fmt};
            REG_CHANNEL_ENABLES: prdata = {29'd0, r_enables};
            REG_CLEAR_TO_BLACK:  prdata = {31'd0, r_black};
            default:             prdata = '0;
        endcase
    end

    nnaf_front #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_fmt   (r_fmt),
        .i_level (q_level),
        .o_push  (fe_push),
        .o_word  (fe_word)
    );

    nnaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_word  (fe_word),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_word  (q_word),
        .o_level (q_level)
    );

    nnaf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_word    (q_word),
        .o_pop     (q_pop),
        .i_fmt     (r_fmt),
        .i_enables (r_enables),
        .i_black   (r_black),
        .o_out     (o_out)
    );

endmodule

FILE: rtl/core/nnaf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnaf_front - pixel intake and line memory
// Tracks column and first-line count, reads the upper neighbor from the line
// memory, writes the incoming pixel back, and pushes neighbor words.
// ----------------------------------------------------------------------------
module nnaf_front #(
    parameter int unsigned LINE_WIDTH = 336
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nnaf_in_if.sink                       i_in,
    input  logic [1:0]                    i_fmt,
    input  logic [nnaf_pkg::Q_CNT_W-1:0]  i_level,
    output logic                          o_push,
    output nnaf_pkg::t_fe_word            o_word
);
    import nnaf_pkg::*;

    localparam int unsigned PTR_W = $clog2(LINE_WIDTH);
    localparam int unsigned POS_W = $clog2(LINE_WIDTH + 1);

    logic [PIX_W-1:0] r_line_mem [LINE_WIDTH];
    logic [PIX_W-1:0] r_rdata;

    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [PIX_W-1:0] r_prev;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_left;
    logic [2:0]       r_s1_raise;
    logic             r_s1_top;

    logic             accept;
    logic [PTR_W-1:0] ptr_eff;
    logic [POS_W-1:0] pos_eff;
    logic [PIX_W-1:0] left_eff;
    logic [PIX_W-1:0] pix;
    logic [Q_CNT_W:0] room_used;

    // Reserve a queue slot for the word in flight
    assign room_used  = {1'b0, i_level} + {{Q_CNT_W{1'b0}}, r_s1_valid};
    assign i_in.ready = (room_used < (Q_CNT_W + 1)'(Q_DEPTH));
    assign accept     = i_in.valid && i_in.ready;

    // Restart neighbor tracking on a frame start
    always_comb begin
        pix      = pix_trim(i_fmt, i_in.pixel_in);
        ptr_eff  = i_in.frame_start ? '0 : r_ptr;
        pos_eff  = i_in.frame_start ? '0 : r_pos;
        left_eff = i_in.frame_start ? '0 : r_prev;
        n_ptr    = (ptr_eff == PTR_W'(LINE_WIDTH - 1)) ? '0 : ptr_eff + PTR_W'(1);
        n_pos    = (pos_eff < POS_W'(LINE_WIDTH)) ? pos_eff + POS_W'(1) : pos_eff;
    end

    // Read the old pixel above, then overwrite it with the new one
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata           <= r_line_mem[ptr_eff];
            r_line_mem[ptr_eff] <= pix;
        end
    end

    // Advance column, first-line count and previous pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_pos  <= '0;
            r_prev <= '0;
        end else if (accept) begin
            r_ptr  <= n_ptr;
            r_pos  <= n_pos;
            r_prev <= pix;
        end
    end

    // Hold the neighbor data while the memory read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_left  <= left_eff;
            r_s1_raise <= {i_in.raise_blue, i_in.raise_green, i_in.raise_red};
            r_s1_top   <= (pos_eff < POS_W'(LINE_WIDTH));
        end
    end

    // Upper neighbor reads as zero on the first line
    assign o_push       = r_s1_valid;
    assign o_word.above = r_s1_top ? '0 : r_rdata;
    assign o_word.left  = r_s1_left;
    assign o_word.raise = r_s1_raise;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_ptr} < (PTR_W + 1)'(LINE_WIDTH))
        else $error("column pointer past line end");

endmodule

FILE: rtl/core/nnaf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnaf_queue - short queue between intake and filter
// Holds neighbor words so intake and output can stall independently.
// ----------------------------------------------------------------------------
module nnaf_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  nnaf_pkg::t_fe_word            i_word,
    input  logic                          i_pop,
    output logic                          o_valid,
    output nnaf_pkg::t_fe_word            o_word,
    output logic [nnaf_pkg::Q_CNT_W-1:0]  o_level
);
    import nnaf_pkg::*;

    t_fe_word           r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_count, n_count;

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_word;
        end
    end

    // Advance pointers and count
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_word  = r_slot[r_rd];
    assign o_level = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == Q_CNT_W'(Q_DEPTH)) |-> !i_push)
        else $error("word pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("word popped from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + Q_CNT_W'(1)))
        else $error("queue count lost a push");

endmodule

FILE: rtl/core/nnaf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnaf_back - channel filter and output register
// Averages the two neighbors per channel, steps up or down, clamps, zeroes
// disabled channels (all in black mode) and registers the output result word.
// ----------------------------------------------------------------------------
module nnaf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  nnaf_pkg::t_fe_word   i_word,
    output logic                 o_pop,
    input  logic [1:0]           i_fmt,
    input  logic [2:0]           i_enables,
    input  logic                 i_black,
    nnaf_out_if.source           o_out
);
    import nnaf_pkg::*;

    logic             r_valid;
    logic [31:0]      r_pixel;
    logic             load;
    logic [PIX_W-1:0] result;
    logic [PIX_W-1:0] m   [3];
    logic [PIX_W-1:0] s   [3];
    logic [PIX_W-1:0] avg [3];
    logic [PIX_W:0]   sum [3];
    logic [PIX_W:0]   up  [3];
    logic [PIX_W-1:0] val [3];

    assign load  = i_valid && (!r_valid || o_out.ready);
    assign o_pop = load;

    // Filter each channel on its own
    always_comb begin
        result = '0;
        for (int c = 0; c < 3; c++) begin
            m[c]   = ch_mask(i_fmt, 2'(c));
            s[c]   = ch_step(i_fmt, 2'(c));
            sum[c] = {1'b0, i_word.above & m[c]} + {1'b0, i_word.left & m[c]};
            avg[c] = sum[c][PIX_W:1] & m[c];
            up[c]  = {1'b0, avg[c]} + {1'b0, s[c]};
            if (i_word.raise[c]) begin
                val[c] = (up[c] > {1'b0, m[c]}) ? m[c] : up[c][PIX_W-1:0];
            end else begin
                val[c] = (avg[c] >= s[c]) ? avg[c] - s[c] : '0;
            end
            if (i_enables[c]) begin
                result = result | val[c];
            end
        end
        if (i_black) begin
            result = '0;
        end
    end

    // Hold the word until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pixel <= {8'd0, result};
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.pixel_out = r_pixel;

endmodule
